FILE: hdl/dacf_pkg.sv
// Shared constants for the depth adaptive color feature block.
// Frame geometry, stream widths and divider sizing; no dependencies.
`default_nettype none

package dacf_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // Coordinate registers hold an input column/row or an in-frame probe
  localparam int X_W     = $clog2(FRAME_WIDTH + 1);
  localparam int Y_W     = $clog2(FRAME_HEIGHT + 1);
  localparam int XY_W    = (X_W > Y_W) ? X_W : Y_W;
  localparam int COORD_W = (XY_W > 10) ? XY_W : 10;

  // Field widths
  localparam int OFF_W   = 9;
  localparam int CH_W    = 2;
  localparam int SCALE_W = 16;
  localparam int DEPTH_W = 16;
  localparam int BYTE_W  = 8;
  localparam int RGB_W   = 3 * BYTE_W;
  localparam int RESP_W  = 9;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Stream widths
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 16;

  // Divider: |offset * scale| <= 256 * 65535 fits in 24 bits
  localparam int NUM_W  = 24;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int PROD_W = OFF_W + SCALE_W + 1;
  localparam int SUM_W  = NUM_W + 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_OFFSET_X  = 3'd0,
    REG_FIRST_OFFSET_Y  = 3'd1,
    REG_SECOND_OFFSET_X = 3'd2,
    REG_SECOND_OFFSET_Y = 3'd3,
    REG_FIRST_CHANNEL   = 3'd4,
    REG_SECOND_CHANNEL  = 3'd5,
    REG_DEPTH_SCALE     = 3'd6
  } cfg_reg_t;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

endpackage

`default_nettype wire

FILE: hdl/dacf_ram.sv
// Generic single-port RAM with registered read data.
// Width and depth come from parameters; no other dependencies.
`default_nettype none

module dacf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: hdl/depth_adaptive_color_feature.sv
// A pixel write holds s_tready low through the index and write states; a full query runs
// the shared bit-serial divider once for each of the four probe offsets before m_tvalid
// rises, and a query outside the frame, at zero depth or with a probe off the frame ends
// sooner. One item is in work at a time; the finished result waits in an output register.
// Reset (rst, synchronous, active high) clears the sequencer, output valid, offsets and
// channels, and sets the depth scale to SCALE_RESET.
//
// Top level of the depth adaptive color feature block.
// Uses dacf_pkg and instances of dacf_ram for the depth and color frames.
`default_nettype none

module depth_adaptive_color_feature (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write port
  input  wire logic                              cfg_wen,
  input  wire logic [dacf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dacf_pkg::CFG_W-1:0]        cfg_data,
  // Input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata: col[9:0], row[18:10], depth_sample[34:19], chan_zero[42:35],
  //          chan_one[50:43], chan_two[58:51], zero[63:59]
  input  wire logic [dacf_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser: command[0]
  input  wire logic [0:0]                        s_tuser,
  // Result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata: response[8:0], zero[15:9]
  output logic      [dacf_pkg::M_TDATA_W-1:0]    m_tdata,
  // m_tuser: valid_res[0]
  output logic      [0:0]                        m_tuser
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_INDEX = 14'b00000000000010,
    S_WRITE = 14'b00000000000100,
    S_DREAD = 14'b00000000001000,
    S_DCHK  = 14'b00000000010000,
    S_MUL   = 14'b00000000100000,
    S_DIV   = 14'b00000001000000,
    S_ADD   = 14'b00000010000000,
    S_P1A   = 14'b00000100000000,
    S_P1R   = 14'b00001000000000,
    S_P2A   = 14'b00010000000000,
    S_P2R   = 14'b00100000000000,
    S_P2L   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [dacf_pkg::OFF_W-1:0]   offset [4];
  logic        [dacf_pkg::CH_W-1:0]    first_channel;
  logic        [dacf_pkg::CH_W-1:0]    second_channel;
  logic        [dacf_pkg::SCALE_W-1:0] depth_scale;

  // Latched input item
  logic                              cmd;
  logic [dacf_pkg::COORD_W-1:0]      col;
  logic [dacf_pkg::COORD_W-1:0]      row;
  logic [dacf_pkg::DEPTH_W-1:0]      depth_sample;
  logic [dacf_pkg::RGB_W-1:0]        rgb_in;

  // Address path and memories
  logic [dacf_pkg::ADDR_W-1:0]       pix_addr;
  logic                              in_frame;
  logic [dacf_pkg::COORD_W-1:0]      ix;
  logic [dacf_pkg::COORD_W-1:0]      iy;
  logic                              mem_we;
  logic [dacf_pkg::DEPTH_W-1:0]      depth_rd;
  logic [dacf_pkg::RGB_W-1:0]        rgb_rd;

  // Shared multiply / divide unit
  logic [1:0]                        k;
  logic [dacf_pkg::DEPTH_W-1:0]      den;
  logic [dacf_pkg::NUM_W-1:0]        num;
  logic [dacf_pkg::DEPTH_W-1:0]      rem;
  logic                              neg;
  logic [dacf_pkg::CNT_W-1:0]        cnt;
  logic signed [dacf_pkg::PROD_W-1:0] prod;
  logic [dacf_pkg::PROD_W-1:0]       prod_mag;
  logic [dacf_pkg::DEPTH_W:0]        trial;
  logic                              qbit;
  logic signed [dacf_pkg::SUM_W-1:0] quot;
  logic signed [dacf_pkg::SUM_W-1:0] sum;
  logic [dacf_pkg::COORD_W-1:0]      base;
  logic                              sum_ok;

  // Probe coordinates: x1, y1, x2, y2
  logic [dacf_pkg::COORD_W-1:0]      probe [4];
  logic                              probe_ok;

  // Result staging and output register
  logic [dacf_pkg::BYTE_W-1:0]       chan_a;
  logic [dacf_pkg::RESP_W-1:0]       res_resp;
  logic                              res_ok;
  logic                              out_valid;
  logic [dacf_pkg::RESP_W-1:0]       out_resp;
  logic                              out_ok;

  function automatic logic [dacf_pkg::BYTE_W-1:0] chan_of(
    input logic [dacf_pkg::RGB_W-1:0] rgb,
    input logic [dacf_pkg::CH_W-1:0]  ch
  );
    logic [dacf_pkg::BYTE_W-1:0] v;
    case (ch)
      2'd0:    v = rgb[7:0];
      2'd1:    v = rgb[15:8];
      2'd2:    v = rgb[23:16];
      default: v = '0;
    endcase
    return v;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        offset[i] <= '0;
      end
      first_channel  <= '0;
      second_channel <= '0;
      depth_scale    <= dacf_pkg::SCALE_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        dacf_pkg::REG_FIRST_OFFSET_X:  offset[0] <= cfg_data[dacf_pkg::OFF_W-1:0];
        dacf_pkg::REG_FIRST_OFFSET_Y:  offset[1] <= cfg_data[dacf_pkg::OFF_W-1:0];
        dacf_pkg::REG_SECOND_OFFSET_X: offset[2] <= cfg_data[dacf_pkg::OFF_W-1:0];
        dacf_pkg::REG_SECOND_OFFSET_Y: offset[3] <= cfg_data[dacf_pkg::OFF_W-1:0];
        dacf_pkg::REG_FIRST_CHANNEL:   first_channel  <= cfg_data[dacf_pkg::CH_W-1:0];
        dacf_pkg::REG_SECOND_CHANNEL:  second_channel <= cfg_data[dacf_pkg::CH_W-1:0];
        dacf_pkg::REG_DEPTH_SCALE:     depth_scale <= cfg_data[dacf_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Select the pixel whose address is formed this cycle
  always_comb begin
    case (state)
      S_P1A:   begin ix = probe[0]; iy = probe[1]; end
      S_P2A:   begin ix = probe[2]; iy = probe[3]; end
      default: begin ix = col;      iy = row;      end
    endcase
  end

  // Shared unit datapath
  assign prod     = offset[k] * $signed({1'b0, depth_scale});
  assign prod_mag = prod[dacf_pkg::PROD_W-1] ? dacf_pkg::PROD_W'(-prod)
                                             : dacf_pkg::PROD_W'(prod);
  assign trial    = {rem, num[dacf_pkg::NUM_W-1]};
  assign qbit     = (trial >= {1'b0, den});
  assign quot     = neg ? -$signed({2'b00, num}) : $signed({2'b00, num});
  assign base     = k[0] ? row : col;
  assign sum      = $signed(dacf_pkg::SUM_W'(base)) + quot;
  assign sum_ok   = !sum[dacf_pkg::SUM_W-1] &&
                    (32'(sum[dacf_pkg::SUM_W-2:0]) <
                     (k[0] ? dacf_pkg::FRAME_HEIGHT : dacf_pkg::FRAME_WIDTH));

  assign mem_we   = (state == S_WRITE) && in_frame;
  assign s_tready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_INDEX;
          end
        end
        S_INDEX: begin
          state <= (cmd == dacf_pkg::CMD_WRITE) ? S_WRITE : S_DREAD;
        end
        S_WRITE: state <= S_IDLE;
        S_DREAD: state <= in_frame ? S_DCHK : S_DONE;
        S_DCHK:  state <= (depth_rd == '0) ? S_DONE : S_MUL;
        S_MUL:   state <= S_DIV;
        S_DIV: begin
          if (cnt == dacf_pkg::CNT_W'(dacf_pkg::NUM_W - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (k == 2'd3) begin
            state <= (probe_ok && sum_ok) ? S_P1A : S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_P1A: state <= S_P1R;
        S_P1R: state <= S_P2A;
        S_P2A: state <= S_P2R;
        S_P2R: state <= S_P2L;
        S_P2L: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd          <= s_tuser[0];
        col          <= dacf_pkg::COORD_W'(s_tdata[9:0]);
        row          <= dacf_pkg::COORD_W'(s_tdata[18:10]);
        depth_sample <= s_tdata[34:19];
        rgb_in       <= s_tdata[58:35];
      end
      S_INDEX: begin
        pix_addr <= dacf_pkg::ADDR_W'(32'(iy) * dacf_pkg::FRAME_WIDTH + 32'(ix));
        in_frame <= (32'(col) < dacf_pkg::FRAME_WIDTH) &&
                    (32'(row) < dacf_pkg::FRAME_HEIGHT);
        res_ok   <= 1'b0;
        res_resp <= '0;
      end
      S_DCHK: begin
        den      <= depth_rd;
        k        <= 2'd0;
        probe_ok <= 1'b1;
      end
      S_MUL: begin
        num <= prod_mag[dacf_pkg::NUM_W-1:0];
        neg <= prod[dacf_pkg::PROD_W-1];
        rem <= '0;
        cnt <= '0;
      end
      S_DIV: begin
        // One restoring step: shift in a numerator bit, subtract when it fits
        rem <= qbit ? dacf_pkg::DEPTH_W'(trial - {1'b0, den})
                    : trial[dacf_pkg::DEPTH_W-1:0];
        num <= {num[dacf_pkg::NUM_W-2:0], qbit};
        cnt <= cnt + 1'b1;
      end
      S_ADD: begin
        probe[k] <= sum[dacf_pkg::COORD_W-1:0];
        probe_ok <= probe_ok && sum_ok;
        k        <= k + 2'd1;
      end
      S_P1A: begin
        pix_addr <= dacf_pkg::ADDR_W'(32'(iy) * dacf_pkg::FRAME_WIDTH + 32'(ix));
      end
      S_P2A: begin
        pix_addr <= dacf_pkg::ADDR_W'(32'(iy) * dacf_pkg::FRAME_WIDTH + 32'(ix));
        chan_a   <= chan_of(rgb_rd, first_channel);
      end
      S_P2L: begin
        res_resp <= {1'b0, chan_a} - {1'b0, chan_of(rgb_rd, second_channel)};
        res_ok   <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || m_tready)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || m_tready)) begin
      out_resp <= res_ok ? res_resp : '0;
      out_ok   <= res_ok;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = dacf_pkg::M_TDATA_W'(out_resp);
  assign m_tuser  = out_ok;

  // Frame memories share one address
  dacf_ram #(
    .WIDTH (dacf_pkg::DEPTH_W),
    .DEPTH (dacf_pkg::PIXELS)
  ) u_depth_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (pix_addr),
    .wdata (depth_sample),
    .rdata (depth_rd)
  );

  dacf_ram #(
    .WIDTH (dacf_pkg::RGB_W),
    .DEPTH (dacf_pkg::PIXELS)
  ) u_color_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (pix_addr),
    .wdata (rgb_in),
    .rdata (rgb_rd)
  );

endmodule

`default_nettype wire

FILE: hdl/dacf_checker.sv
// Port-level checks for depth_adaptive_color_feature, bound to the top level.
// Uses dacf_pkg for port widths.
`default_nettype none

module dacf_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [dacf_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [0:0]                     m_tuser
);

  // No result is shown right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Not ready in the cycle after every input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready held across an input transfer");

  // Invalid results carry a zero response
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("invalid result with nonzero response");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind depth_adaptive_color_feature dacf_checker u_dacf_checker (.*);

`default_nettype wire
